// ----- hdl/lsh_pkg.sv -----
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types, constants and arithmetic for the 3x3 Laplacian sharpener.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsh_pkg;

    localparam int PIX_W    = 8;
    localparam int ROW_W    = 12;
    localparam int FW_W     = 11;
    localparam int FH_W     = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 1;
    localparam int WIN_N    = 3;

    localparam int HEIGHT_MAX       = 4096;
    localparam int DIM_MIN          = 3;
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // one window column: rows top/middle/bottom
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } col_t;

    // 4-neighbour Laplacian clamped to 0..255
    function automatic logic [PIX_W-1:0] lap_clamp(
        input logic [PIX_W-1:0] up,
        input logic [PIX_W-1:0] down,
        input logic [PIX_W-1:0] left,
        input logic [PIX_W-1:0] right,
        input logic [PIX_W-1:0] centre
    );
        logic [PIX_W+1:0]        sum;
        logic signed [PIX_W+2:0] lap;
        logic [PIX_W-1:0]        q;
        sum = {2'b00, up} + {2'b00, down} + {2'b00, left} + {2'b00, right};
        lap = $signed({1'b0, sum}) - $signed({1'b0, centre, 2'b00});
        if (lap < 0)
            q = '0;
        else if (lap > 255)
            q = '1;
        else
            q = lap[PIX_W-1:0];
        return q;
    endfunction

    // p - ceil(q/2), saturated at zero
    function automatic logic [PIX_W-1:0] sharpen(
        input logic [PIX_W-1:0] p,
        input logic [PIX_W-1:0] q
    );
        logic [PIX_W:0]   q_inc;
        logic [PIX_W-1:0] half;
        logic [PIX_W-1:0] res;
        q_inc = {1'b0, q} + {{PIX_W{1'b0}}, 1'b1};
        half  = q_inc[PIX_W:1];
        if (p >= half)
            res = p - half;
        else
            res = '0;
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/lsh_ram.sv -----
// ----------------------------------------------------------------------------
// lsh_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hdl/lsh_cell.sv -----
// ----------------------------------------------------------------------------
// lsh_cell
// One column of the 3x3 window; loads its neighbor's column on each shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsh_cell
    import lsh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic shift_en,
    input  wire col_t col_in,
    output col_t      col_out
);

    col_t col_reg;
    col_t col_next;

    always_comb
    begin
        col_next = shift_en ? col_in : col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col_reg <= '0;
        else
            col_reg <= col_next;
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

// ----- hdl/laplacian_sharpen_3x3.sv -----
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3
// Raster-order 3x3 Laplacian sharpening of an 8-bit grayscale stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, kind, pixel_in): one request per pixel
//   in raster order, kind = pixel. After the frame's last pixel, flush
//   requests (kind = flush) drain the remaining frame_width+1 results; a
//   flush with nothing pending is taken and yields nothing.
//   Output channel (out_valid/out_ready, pixel_out, frame_end): results in
//   raster order, frame_end on the frame's last pixel.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   a write to frame_width or frame_height restarts the frame. Write only
//   while idle.
//   Throughput: one request per cycle while out_ready holds. The result for
//   pixel n leaves with request n+frame_width+1, after that request passes
//   the line-store read, window shift, Laplacian clamp and output register.
//   A stalled receiver holds the output register; the pipeline keeps taking
//   requests until its empty stages fill, then in_ready drops.
//   Reset: frame 640x480, counters and window cleared, line stores untouched.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module laplacian_sharpen_3x3
    import lsh_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 kind,
    input  wire logic [PIX_W-1:0]     pixel_in,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [PIX_W-1:0]     pixel_out,
    output logic                      frame_end,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int RST_W = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;

    // frame geometry, kept as size-1 and size-2
    logic [COL_W-1:0] w_m1_reg, w_m1_next;
    logic [COL_W-1:0] w_m2_reg, w_m2_next;
    logic [ROW_W-1:0] h_m1_reg, h_m1_next;
    logic [ROW_W-1:0] h_m2_reg, h_m2_next;

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             draining_reg, draining_next;

    // stage 1: line-store read in flight
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_pix_item_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             s1_emit_reg;
    logic             s1_interior_reg;
    logic             s1_fend_reg;
    logic [COL_W-1:0] s1_addr_reg;

    // stage 2: window holds the item's neighborhood
    logic             s2_valid_reg, s2_valid_next;
    logic             s2_interior_reg;
    logic             s2_fend_reg;

    // stage 3: clamped Laplacian
    logic             s3_valid_reg, s3_valid_next;
    logic [PIX_W-1:0] s3_q_reg;
    logic [PIX_W-1:0] s3_p_reg;
    logic             s3_fend_reg;

    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] pixel_out_reg;
    logic             frame_end_reg;

    logic             in_acc;
    logic             cfg_acc;
    logic             is_pix;
    logic             restart_now;
    logic             go;
    logic             emit;
    logic             row_ready;
    logic             at_origin;
    logic             interior;
    logic             fend;
    logic [COL_W-1:0] b_in_col;
    logic [ROW_W-1:0] b_in_row;
    logic [COL_W-1:0] b_out_col;
    logic [ROW_W-1:0] b_out_row;
    logic [31:0]      w_eff;
    logic [31:0]      h_eff;

    logic             ready_out;
    logic             ready_3;
    logic             ready_2;
    logic             s1_adv;
    logic             s2_adv;
    logic             s3_adv;

    logic [PIX_W-1:0] upper_rd;
    logic [PIX_W-1:0] middle_rd;
    col_t             chain [WIN_N+1];
    logic [PIX_W-1:0] q_calc;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign ready_out = !out_valid_reg || out_ready;
    assign ready_3   = !s3_valid_reg || ready_out;
    assign ready_2   = !s2_valid_reg || ready_3;
    assign s3_adv    = s3_valid_reg && ready_out;
    assign s2_adv    = s2_valid_reg && ready_3;
    assign s1_adv    = s1_valid_reg && ready_2;

    assign in_ready  = !s1_valid_reg || ready_2;
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid;

    // ------------------------------------------------------------------
    // position tracking and configuration
    // ------------------------------------------------------------------
    always_comb
    begin
        is_pix      = (kind == KIND_PIXEL);
        restart_now = is_pix && draining_reg;
        b_in_col    = restart_now ? '0 : in_col_reg;
        b_in_row    = restart_now ? '0 : in_row_reg;
        b_out_col   = restart_now ? '0 : out_col_reg;
        b_out_row   = restart_now ? '0 : out_row_reg;
        at_origin   = (out_row_reg == '0) && (out_col_reg == '0);

        // a flush only does work while a drained frame has results left
        go        = is_pix || (draining_reg && !at_origin);
        row_ready = (b_in_row > ROW_W'(1)) || ((b_in_row == ROW_W'(1)) && (b_in_col != '0));
        emit      = is_pix ? row_ready : go;

        interior = (b_out_row != '0) && (b_out_row <= h_m2_reg) &&
                   (b_out_col != '0) && (b_out_col <= w_m2_reg);
        fend     = (b_out_row == h_m1_reg) && (b_out_col == w_m1_reg);

        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        draining_next = draining_reg;
        w_m1_next     = w_m1_reg;
        w_m2_next     = w_m2_reg;
        h_m1_next     = h_m1_reg;
        h_m2_next     = h_m2_reg;
        w_eff         = 32'(cfg_data[FW_W-1:0]);
        h_eff         = 32'(cfg_data[FH_W-1:0]);

        if (w_eff < 32'(DIM_MIN))
            w_eff = 32'(DIM_MIN);
        else if (w_eff > 32'(MAX_WIDTH))
            w_eff = 32'(MAX_WIDTH);
        if (h_eff < 32'(DIM_MIN))
            h_eff = 32'(DIM_MIN);
        else if (h_eff > 32'(HEIGHT_MAX))
            h_eff = 32'(HEIGHT_MAX);

        if (cfg_acc)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    w_m1_next = COL_W'(w_eff - 32'd1);
                    w_m2_next = COL_W'(w_eff - 32'd2);
                end
                REG_FRAME_HEIGHT:
                begin
                    h_m1_next = ROW_W'(h_eff - 32'd1);
                    h_m2_next = ROW_W'(h_eff - 32'd2);
                end
                default:
                begin
                    w_m1_next = w_m1_reg;
                end
            endcase
            in_col_next   = '0;
            in_row_next   = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            draining_next = 1'b0;
        end
        else if (in_acc)
        begin
            in_col_next   = b_in_col;
            in_row_next   = b_in_row;
            out_col_next  = b_out_col;
            out_row_next  = b_out_row;
            draining_next = restart_now ? 1'b0 : draining_reg;
            if (go)
            begin
                if (b_in_col == w_m1_reg)
                begin
                    in_col_next = '0;
                    if (is_pix)
                    begin
                        if (b_in_row == h_m1_reg)
                        begin
                            in_row_next   = '0;
                            draining_next = 1'b1;
                        end
                        else
                        begin
                            in_row_next = b_in_row + ROW_W'(1);
                        end
                    end
                end
                else
                begin
                    in_col_next = b_in_col + COL_W'(1);
                end
            end
            if (emit)
            begin
                if (b_out_col == w_m1_reg)
                begin
                    out_col_next = '0;
                    out_row_next = (b_out_row == h_m1_reg) ? '0 : b_out_row + ROW_W'(1);
                end
                else
                begin
                    out_col_next = b_out_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_m1_reg     <= COL_W'(RST_W - 1);
            w_m2_reg     <= COL_W'(RST_W - 2);
            h_m1_reg     <= ROW_W'(FRAME_HEIGHT_RST - 1);
            h_m2_reg     <= ROW_W'(FRAME_HEIGHT_RST - 2);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            draining_reg <= 1'b0;
        end
        else
        begin
            w_m1_reg     <= w_m1_next;
            w_m2_reg     <= w_m2_next;
            h_m1_reg     <= h_m1_next;
            h_m2_reg     <= h_m2_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            draining_reg <= draining_next;
        end
    end

    // ------------------------------------------------------------------
    // pipeline valid bits
    // ------------------------------------------------------------------
    always_comb
    begin
        if (in_acc && go)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_adv)
            s2_valid_next = s1_emit_reg;
        else if (s2_adv)
            s2_valid_next = 1'b0;
        else
            s2_valid_next = s2_valid_reg;

        if (s2_adv)
            s3_valid_next = 1'b1;
        else if (s3_adv)
            s3_valid_next = 1'b0;
        else
            s3_valid_next = s3_valid_reg;

        if (s3_adv)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // pipeline payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_acc && go)
        begin
            s1_pix_item_reg <= is_pix;
            s1_pix_reg      <= is_pix ? pixel_in : '0;
            s1_emit_reg     <= emit;
            s1_interior_reg <= interior;
            s1_fend_reg     <= fend;
            s1_addr_reg     <= b_in_col;
        end
        if (s1_adv)
        begin
            s2_interior_reg <= s1_interior_reg;
            s2_fend_reg     <= s1_fend_reg;
        end
        if (s2_adv)
        begin
            s3_q_reg    <= q_calc;
            s3_p_reg    <= chain[1].mid;
            s3_fend_reg <= s2_fend_reg;
        end
        if (s3_adv)
        begin
            pixel_out_reg <= sharpen(s3_p_reg, s3_q_reg);
            frame_end_reg <= s3_fend_reg;
        end
    end

    // ------------------------------------------------------------------
    // line stores: upper takes the old middle row, middle the new pixel
    // ------------------------------------------------------------------
    lsh_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_store (
        .clk     (clk),
        .wr_en   (s1_adv && s1_pix_item_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (middle_rd),
        .rd_en   (in_acc && go),
        .rd_addr (b_in_col),
        .rd_data (upper_rd)
    );

    lsh_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_store (
        .clk     (clk),
        .wr_en   (s1_adv && s1_pix_item_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (in_acc && go),
        .rd_addr (b_in_col),
        .rd_data (middle_rd)
    );

    // ------------------------------------------------------------------
    // window: chain of column cells, newest column enters at the right
    // ------------------------------------------------------------------
    assign chain[WIN_N] = {upper_rd, middle_rd, s1_pix_reg};

    for (genvar k = 0; k < WIN_N; k++)
    begin : g_win
        lsh_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (s1_adv),
            .col_in   (chain[k+1]),
            .col_out  (chain[k])
        );
    end

    // border pixels pass through: q of zero leaves the centre unchanged
    always_comb
    begin
        if (s2_interior_reg)
            q_calc = lap_clamp(chain[1].top, chain[1].bot, chain[0].mid,
                               chain[2].mid, chain[1].mid);
        else
            q_calc = '0;
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign frame_end = frame_end_reg;

endmodule

`default_nettype wire

// ----- tb/laplacian_sharpen_3x3_test.sv -----
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_test
// Self-checking bench for the 3x3 Laplacian sharpener. A clocked driver feeds
// pixel, flush and register-write requests from a pending queue. A bit-exact
// predictor runs on every accepted request. A clocked monitor compares each
// accepted result with the oldest predicted one. Random idling is applied on
// both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module laplacian_sharpen_3x3_test;
    import lsh_pkg::*;

    localparam int LINE_MAX      = 1024;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int TAIL_ITEMS    = 64;
    localparam int RANDOM_ITEMS  = 450;
    localparam int REPORT_MAX    = 10;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PATTERN_LEN   = 9;

    typedef enum logic {REQ_STREAM, REQ_REGWRITE} req_e;
    typedef enum int {STYLE_UNIFORM, STYLE_EXTREME, STYLE_SMOOTH} pix_style_e;

    typedef struct {
        req_e                 op;
        logic                 kind;
        logic [PIX_W-1:0]     pix;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } request_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             last;
    } sharp_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 kind = KIND_PIXEL;
    logic [PIX_W-1:0]     pixel_in = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PIX_W-1:0]     pixel_out;
    logic                 frame_end;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;

    laplacian_sharpen_3x3 #(
        .MAX_WIDTH (LINE_MAX)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state
    // ------------------------------------------------------------------
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [PIX_W-1:0] upper_line  [LINE_MAX];
    logic [PIX_W-1:0] middle_line [LINE_MAX];
    logic [PIX_W-1:0] win [WIN_N][WIN_N];
    int unsigned      in_col, in_row, out_col, out_row;
    bit               draining;

    request_t pending[$];
    sharp_t   sharpened_q[$];
    int       mismatches = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < DIM_MIN)
            v = DIM_MIN;
        if (v > hi)
            v = hi;
        return v;
    endfunction

    function automatic void restart_frame();
        in_col   = 0;
        in_row   = 0;
        out_col  = 0;
        out_row  = 0;
        draining = 1'b0;
    endfunction

    function automatic void reset_model();
        width_reg  = FW_W'(FRAME_WIDTH_RST);
        height_reg = FH_W'(FRAME_HEIGHT_RST);
        for (int i = 0; i < LINE_MAX; i++)
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int r = 0; r < WIN_N; r++)
            for (int c = 0; c < WIN_N; c++)
                win[r][c] = '0;
        restart_frame();
    endfunction

    function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0] data);
        if (idx == REG_FRAME_WIDTH)
            width_reg = data[FW_W-1:0];
        else
            height_reg = data[FH_W-1:0];
        restart_frame();
    endfunction

    function automatic void shift_in(input logic [PIX_W-1:0] top,
                                     input logic [PIX_W-1:0] mid,
                                     input logic [PIX_W-1:0] bot);
        for (int r = 0; r < WIN_N; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = bot;
    endfunction

    // result for the current output position, then advance it
    function automatic sharp_t emit_result(input int unsigned w, input int unsigned h);
        sharp_t r;
        int     p, lap, q, v;
        p = int'(win[1][1]);
        v = p;
        if (out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w)
        begin
            lap = int'(win[0][1]) + int'(win[2][1]) + int'(win[1][0]) + int'(win[1][2])
                - 4 * p;
            q = (lap < 0) ? 0 : ((lap > 255) ? 255 : lap);
            v = p - ((q + 1) >> 1);
            if (v < 0)
                v = 0;
        end
        r.pix  = PIX_W'(v);
        r.last = (out_row + 1 == h) && (out_col + 1 == w);
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
            if (out_row >= h)
                out_row = 0;
        end
        return r;
    endfunction

    function automatic bit sharpen_step(input logic knd, input logic [PIX_W-1:0] pix,
                                        output sharp_t res);
        int unsigned w, h, c;
        bit          ready;
        w   = clamp_dim(width_reg, LINE_MAX);
        h   = clamp_dim(height_reg, HEIGHT_MAX);
        res = '0;
        if (knd == KIND_FLUSH)
        begin
            // nothing pending: frame incomplete or already drained
            if (!draining || (out_row == 0 && out_col == 0))
                return 1'b0;
            c = (in_col < w) ? in_col : 0;
            shift_in(upper_line[c], middle_line[c], '0);
            in_col = (c + 1 >= w) ? 0 : c + 1;
            res = emit_result(w, h);
            return 1'b1;
        end
        // first pixel of a new frame drops whatever is still pending
        if (draining)
            restart_frame();
        c = (in_col < w) ? in_col : 0;
        shift_in(upper_line[c], middle_line[c], pix);
        upper_line[c]  = middle_line[c];
        middle_line[c] = pix;
        ready = (in_row > 1) || (in_row == 1 && c >= 1);
        in_col = c + 1;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
            if (in_row >= h)
            begin
                in_row   = 0;
                draining = 1'b1;
            end
        end
        if (ready)
        begin
            res = emit_result(w, h);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void note_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%s", msg);
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    int       quiet_cycles, gap_left, calm_left;
    bit       send_in, send_cfg;
    logic     tail_phase = 1'b0;
    request_t req;
    sharp_t   next_result;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            cfg_valid  <= 1'b0;
            tail_phase <= 1'b0;
            reset_model();
            quiet_cycles = 0;
            gap_left     = 0;
            calm_left    = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (sharpen_step(kind, pixel_in, next_result))
                    sharpened_q.push_back(next_result);
                quiet_cycles = 0;
            end
            else if (cfg_valid && cfg_ready)
            begin
                write_register(cfg_index, cfg_data);
                quiet_cycles = 0;
            end
            else if (quiet_cycles < SETTLE_CYCLES)
                quiet_cycles++;

            tail_phase <= (pending.size() <= TAIL_ITEMS);

            if (!(in_valid && !in_ready) && !(cfg_valid && !cfg_ready))
            begin
                send_in  = 1'b0;
                send_cfg = 1'b0;
                if (pending.size() != 0)
                begin
                    if (pending[0].op == REQ_REGWRITE)
                    begin
                        // register writes only once the block has gone quiet
                        if (sharpened_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES)
                        begin
                            req = pending.pop_front();
                            cfg_index <= req.idx;
                            cfg_data  <= req.data;
                            send_cfg = 1'b1;
                        end
                    end
                    else if (gap_left != 0)
                        gap_left--;
                    else
                    begin
                        req = pending.pop_front();
                        kind     <= req.kind;
                        pixel_in <= req.pix;
                        send_in = 1'b1;
                        if (calm_left != 0)
                            calm_left--;
                        else if (pending.size() > TAIL_ITEMS)
                        begin
                            if ($urandom_range(0, 63) == 0)
                                calm_left = $urandom_range(16, 64);
                            else if ($urandom_range(0, 5) == 0)
                                gap_left = $urandom_range(1, 6);
                        end
                    end
                end
                in_valid  <= send_in;
                cfg_valid <= send_cfg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    int     stall_left = 0;
    int     stall_calm = 0;
    int     result_count = 0;
    sharp_t want;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (sharpened_q.size() == 0)
                    note_error($sformatf("result %0d unexpected: pixel_out=%0d frame_end=%0b",
                                         result_count, pixel_out, frame_end));
                else
                begin
                    want = sharpened_q.pop_front();
                    if (pixel_out !== want.pix)
                        note_error($sformatf("result %0d pixel_out: expected %0d, got %0d",
                                             result_count, want.pix, pixel_out));
                    if (frame_end !== want.last)
                        note_error($sformatf("result %0d frame_end: expected %0b, got %0b",
                                             result_count, want.last, frame_end));
                end
                result_count++;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (stall_calm != 0)
                    stall_calm--;
                else if (!tail_phase)
                begin
                    if ($urandom_range(0, 63) == 0)
                        stall_calm = $urandom_range(16, 64);
                    else if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(1, 6);
                end
            end
        end
    end

    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL laplacian_sharpen_3x3");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int unsigned gen_w = FRAME_WIDTH_RST;
    int unsigned gen_h = FRAME_HEIGHT_RST;

    function automatic void push_pixel(input logic [PIX_W-1:0] pix);
        request_t r;
        r = '{REQ_STREAM, KIND_PIXEL, pix, REG_FRAME_WIDTH, '0};
        pending.push_back(r);
    endfunction

    function automatic void push_flushes(input int n);
        request_t r;
        for (int i = 0; i < n; i++)
        begin
            r = '{REQ_STREAM, KIND_FLUSH, PIX_W'($urandom), REG_FRAME_WIDTH, '0};
            pending.push_back(r);
        end
    endfunction

    function automatic void push_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] data);
        request_t r;
        r = '{REQ_REGWRITE, KIND_PIXEL, '0, idx, data};
        pending.push_back(r);
        if (idx == REG_FRAME_WIDTH)
            gen_w = clamp_dim(data[FW_W-1:0], LINE_MAX);
        else
            gen_h = clamp_dim(data[FH_W-1:0], HEIGHT_MAX);
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel(input pix_style_e style);
        if (style == STYLE_EXTREME || $urandom_range(0, 15) == 0)
            return $urandom_range(0, 1) ? '1 : '0;
        if (style == STYLE_SMOOTH)
            return PIX_W'($urandom_range(100, 140));
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // n_pix pixels of the current frame, stray flushes mixed in before the
    // frame is complete, then n_flush trailing flushes
    function automatic void queue_frame(input int n_pix, input int n_flush,
                                        input pix_style_e style);
        for (int i = 0; i < n_pix; i++)
        begin
            push_pixel(random_pixel(style));
            if (i + 1 < gen_w * gen_h && $urandom_range(0, 15) == 0)
                push_flushes(1);
        end
        push_flushes(n_flush);
    endfunction

    logic [PIX_W-1:0] patterns [3][PATTERN_LEN] = '{
        '{255, 255, 255, 255,   0, 255, 255, 255, 255},   // saturates low
        '{201, 201, 201, 201, 200, 202, 201, 201, 201},   // odd q, rounds up
        '{  0,   0,   0,   0, 255,   0,   0,   0,   0}    // negative Laplacian
    };
    int pattern_flushes [3] = '{6, 2, 4};   // full drain, partial drain, full drain

    int          counted;
    int          full, sel;
    bit          must_restart;
    pix_style_e  style;

    initial
    begin
        // flushes with nothing pending, then one row and five pixels at the reset size
        push_flushes(2);
        queue_frame(FRAME_WIDTH_RST + 5, 0, STYLE_UNIFORM);

        // width and height below range clamp to 3x3; the write also drops
        // the unfinished frame above
        push_write(REG_FRAME_WIDTH, '0);
        push_write(REG_FRAME_HEIGHT, CFG_W'(2));
        for (int p = 0; p < 3; p++)
        begin
            for (int i = 0; i < PATTERN_LEN; i++)
                push_pixel(patterns[p][i]);
            push_flushes(pattern_flushes[p]);
        end

        // width above range (all data bits set) clamps to the line length;
        // first rows only, dropped by the next write
        push_write(REG_FRAME_WIDTH, '1);
        queue_frame(LINE_MAX + 4, 0, STYLE_UNIFORM);

        // height above range clamps; a few rows only
        push_write(REG_FRAME_WIDTH, CFG_W'(3));
        push_write(REG_FRAME_HEIGHT, '1);
        queue_frame(3 * 4, 0, STYLE_SMOOTH);
        push_write(REG_FRAME_HEIGHT, '0);

        counted      = 0;
        must_restart = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            if (must_restart || $urandom_range(0, 3) == 0)
            begin
                sel = $urandom_range(0, 2);
                if (sel != 1)
                    push_write(REG_FRAME_WIDTH,
                               CFG_W'(($urandom_range(0, 3) << FW_W) | $urandom_range(0, 9)));
                if (sel != 0)
                    push_write(REG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 7)));
                must_restart = 1'b0;
            end
            style = pix_style_e'($urandom_range(0, 2));
            full  = gen_w * gen_h;
            sel   = $urandom_range(0, 19);
            if (sel < 14)
            begin
                sel = gen_w + 1 + $urandom_range(0, 2);
                queue_frame(full, sel, style);
                counted += full + sel;
            end
            else if (sel < 17)
            begin
                // next frame starts before this one is drained
                sel = $urandom_range(0, gen_w);
                queue_frame(full, sel, style);
                counted += full + sel;
            end
            else
            begin
                // unfinished frame, dropped by the next register write
                sel = $urandom_range(1, full - 1);
                queue_frame(sel, 0, style);
                counted += sel;
                must_restart = 1'b1;
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || in_valid || cfg_valid || sharpened_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && sharpened_q.size() == 0)
            $display("PASS laplacian_sharpen_3x3");
        else
            $display("FAIL laplacian_sharpen_3x3");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/lsh_pkg.sv
hdl/lsh_ram.sv
hdl/lsh_cell.sv
hdl/laplacian_sharpen_3x3.sv
tb/laplacian_sharpen_3x3_test.sv
